>>> design/three_wheel_odometry_core_macros.svh
// Assertion macros for the three-wheel odometry core.
// Used by the top level; no other dependencies.
`ifndef THREE_WHEEL_ODOMETRY_CORE_MACROS_SVH
`define THREE_WHEEL_ODOMETRY_CORE_MACROS_SVH
`ifndef SYNTH
`define ODO_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("odometry assertion failed");
`define ODO_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("odometry assertion failed");
`else
`define ODO_ASSERT(lbl, clk, rst, prop)
`define ODO_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> design/tw_odo_pkg.sv
// Shared types, constants and the arctangent table of the odometry core.
// No dependencies.
package tw_odo_pkg;

   localparam int TRIG_ITERATIONS = 24;
   localparam logic [29:0] TURN_CONST = 30'd683565276;
   localparam logic signed [31:0] CORDIC_START = 32'sd652032874;
   localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
   localparam int DIVIDEND_W = 90;
   localparam int DIVISOR_W = 92;
   localparam int QUOT_W = 62;
   localparam int DIV_CNT_W = 6;
   localparam logic [DIV_CNT_W-1:0] BAM_BITS = 6'd62;
   localparam logic [DIV_CNT_W-1:0] CHORD_BITS = 6'd31;

   typedef enum logic [2:0] {
      REG_LEFT_SCALE, REG_RIGHT_SCALE, REG_MIDDLE_SCALE, REG_LEFT_OFFSET,
      REG_RIGHT_OFFSET, REG_MIDDLE_OFFSET, REG_INIT_POSITION, REG_INIT_HEADING
   } reg_index_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_MUL_L, OP_MUL_R, OP_MUL_M, OP_NUM, OP_BAMMUL,
      OP_DIV_BAM, OP_HALF, OP_A1, OP_A2, OP_A3, OP_P1, OP_P2, OP_P3,
      OP_DIV_CH, OP_CHORD, OP_POS, OP_X1, OP_X2, OP_X3, OP_Y1, OP_Y2, OP_PUSH
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MUL_L, ST_MUL_R, ST_MUL_M, ST_NUM, ST_BAMMUL, ST_DIV_BAM,
      ST_BAM_WAIT, ST_HALF, ST_HALF_WAIT, ST_A1, ST_A2, ST_A3, ST_P1, ST_P2,
      ST_P3, ST_DIV_CH, ST_CH_WAIT, ST_CHORD, ST_POS, ST_POS_WAIT, ST_X1,
      ST_X2, ST_X3, ST_Y1, ST_Y2, ST_PUSH
   } state_type;

   typedef struct packed {
      op_type op;
      logic   pass;
   } cmd_type;

   typedef struct packed {
      logic turn;
      logic div_busy;
      logic cordic_busy;
      logic out_free;
   } status_type;

   function automatic logic [31:0] atan_bam(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0: v = 32'd536870912;
         5'd1: v = 32'd316933406;
         5'd2: v = 32'd167458907;
         5'd3: v = 32'd85004756;
         5'd4: v = 32'd42667331;
         5'd5: v = 32'd21354465;
         5'd6: v = 32'd10679838;
         5'd7: v = 32'd5340245;
         5'd8: v = 32'd2670163;
         5'd9: v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

>>> design/tw_odo_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tw_odo_pkg.
module tw_odo_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [tw_odo_pkg::DIVIDEND_W-1:0]      dividend,
   input  logic [tw_odo_pkg::DIVISOR_W-1:0]       divisor_top,
   input  logic [tw_odo_pkg::DIV_CNT_W-1:0]       bits,
   output logic                                   busy,
   output logic [tw_odo_pkg::QUOT_W-1:0]          quotient,
   output logic [tw_odo_pkg::DIVIDEND_W-1:0]      remainder
);
   logic [tw_odo_pkg::DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [tw_odo_pkg::DIVISOR_W-1:0]  dsh_ff, dsh_in;
   logic [tw_odo_pkg::QUOT_W-1:0]     q_ff, q_in;
   logic [tw_odo_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                              busy_ff, busy_in;
   logic                              ge_w;

   always_comb begin
      ge_w = {{(tw_odo_pkg::DIVISOR_W-tw_odo_pkg::DIVIDEND_W){1'b0}}, rem_ff} >= dsh_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in = dividend;
         dsh_in = divisor_top;
         q_in = '0;
         cnt_in = bits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // subtract where the shifted divisor fits, then move one place down
         if (ge_w) begin
            rem_in = rem_ff - dsh_ff[tw_odo_pkg::DIVIDEND_W-1:0];
         end
         q_in = {q_ff[tw_odo_pkg::QUOT_W-2:0], ge_w};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         busy_in = (cnt_ff != 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
   end

   assign busy = busy_ff;
   assign quotient = q_ff;
   assign remainder = rem_ff;
endmodule

>>> design/tw_odo_cordic.sv
// Iterative CORDIC sine and cosine of a binary angle, one rotation per cycle.
// Depends on tw_odo_pkg.
module tw_odo_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        angle,
   output logic               busy,
   output logic signed [31:0] sin_out,
   output logic signed [31:0] cos_out
);
   logic signed [31:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [31:0] sx_w, sy_w, atan_w;
   logic [31:0]        sum_w;
   logic [1:0]         quad_ff, quad_in;
   logic [4:0]         iter_ff, iter_in;
   logic               busy_ff, busy_in;

   always_comb begin
      sum_w = angle + 32'h2000_0000;
      sx_w = x_ff >>> iter_ff;
      sy_w = y_ff >>> iter_ff;
      atan_w = $signed(tw_odo_pkg::atan_bam(iter_ff));
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      quad_in = quad_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      if (start) begin
         // fold the angle into the octant around the nearest axis
         quad_in = sum_w[31:30];
         z_in = $signed(angle - {sum_w[31:30], 30'd0});
         x_in = tw_odo_pkg::CORDIC_START;
         y_in = '0;
         iter_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[31]) begin
            x_in = x_ff - sy_w;
            y_in = y_ff + sx_w;
            z_in = z_ff - atan_w;
         end else begin
            x_in = x_ff + sy_w;
            y_in = y_ff - sx_w;
            z_in = z_ff + atan_w;
         end
         iter_in = iter_ff + 5'd1;
         busy_in = (iter_ff != 5'(tw_odo_pkg::TRIG_ITERATIONS - 1));
      end
   end

   always_comb begin
      case (quad_ff)
         2'd0: begin cos_out = x_ff; sin_out = y_ff; end
         2'd1: begin cos_out = -y_ff; sin_out = x_ff; end
         2'd2: begin cos_out = -x_ff; sin_out = -y_ff; end
         default: begin cos_out = y_ff; sin_out = -x_ff; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      quad_ff <= quad_in;
      iter_ff <= iter_in;
   end

   assign busy = busy_ff;
endmodule

>>> design/tw_odo_datapath.sv
// Odometry datapath: configuration, wheel state, shared multiplier, divider and
// CORDIC, driven by micro-operations. Depends on tw_odo_pkg, tw_odo_div, tw_odo_cordic.
module tw_odo_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  tw_odo_pkg::cmd_type    cmd,
   output tw_odo_pkg::status_type status,
   input  logic [95:0]            req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [95:0]            rsp_tdata,
   input  logic                   csr_valid,
   input  logic [2:0]             csr_index,
   input  logic [63:0]            csr_data
);
   // configuration
   logic [31:0] lscale_ff, lscale_in, rscale_ff, rscale_in, mscale_ff, mscale_in;
   logic [23:0] loff_ff, loff_in, roff_ff, roff_in, moff_ff, moff_in;
   // wheel state and accumulators
   logic [31:0] prev_ff [3];
   logic [31:0] prev_in [3];
   logic [31:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in, acc_h_ff, acc_h_in;
   // working registers
   logic [31:0]        mag_ff [3];
   logic [31:0]        mag_in [3];
   logic [2:0]         sgn_ff, sgn_in;
   logic signed [31:0] dl_ff, dl_in, dr_ff, dr_in, dm_ff, dm_in, h_ff, h_in, h2_ff, h2_in;
   logic signed [32:0] num_ff, num_in;
   logic [31:0]        bam_ff, bam_in, half_ff, half_in;
   logic signed [63:0] t_ff, t_in;
   logic signed [58:0] a_ff, a_in;
   logic [89:0]        pacc_ff, pacc_in;
   logic               ovf_ff, ovf_in;
   logic [63:0]        prod_ff;
   logic [31:0]        mul_a, mul_b;
   logic [31:0]        out_x_ff, out_x_in, out_y_ff, out_y_in, out_h_ff, out_h_in;
   logic               rsp_valid_ff, rsp_valid_in;
   // combinational helpers
   logic signed [32:0] diff_w [3];
   logic [24:0]        den_w;
   logic               num_neg_w;
   logic [31:0]        num_mag_w;
   logic signed [31:0] sin_w, cos_w, d_sel_w, hsign_w;
   logic [31:0]        s_mag_w, c_mag_w, h_mag_w, h2_mag_w, d_mag_w, us_w, qr_w;
   logic [23:0]        off_sel_w;
   logic [57:0]        ua_w;
   logic [61:0]        ud_w;
   logic               round_up_w, chord_neg_w;
   logic signed [63:0] v_w;
   // divider and CORDIC hookup
   logic                                  div_start, div_busy;
   logic [tw_odo_pkg::DIVIDEND_W-1:0]     div_dividend, div_rem;
   logic [tw_odo_pkg::DIVISOR_W-1:0]      div_divisor;
   logic [tw_odo_pkg::DIV_CNT_W-1:0]      div_bits;
   logic [tw_odo_pkg::QUOT_W-1:0]         div_q;
   logic                                  cor_start, cor_busy;
   logic [31:0]                           cor_angle;

   function automatic logic signed [31:0] dist_of(input logic [63:0] p, input logic neg);
      logic [56:0] r;
      logic [31:0] m;
      r = {1'b0, p[63:8]} + 57'(p[7]);
      m = (r > 57'(tw_odo_pkg::SAT_MAX)) ? tw_odo_pkg::SAT_MAX : r[31:0];
      return neg ? $signed(32'd0 - m) : $signed(m);
   endfunction

   function automatic logic signed [63:0] signed_of(input logic [63:0] p, input logic neg);
      return neg ? $signed(64'd0 - p) : $signed(p);
   endfunction

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      return v[31] ? 32'd0 - v : v;
   endfunction

   function automatic logic [31:0] round30(input logic signed [63:0] v);
      logic [63:0] m;
      logic [63:0] r;
      m = v[63] ? 64'd0 - v : v;
      r = (m + 64'd536870912) >> 30;
      return v[63] ? 32'd0 - r[31:0] : r[31:0];
   endfunction

   tw_odo_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend    (div_dividend),
      .divisor_top (div_divisor),
      .bits        (div_bits),
      .busy        (div_busy),
      .quotient    (div_q),
      .remainder   (div_rem)
   );

   tw_odo_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .busy    (cor_busy),
      .sin_out (sin_w),
      .cos_out (cos_w)
   );

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         diff_w[j] = {req_tdata[32*j+31], req_tdata[32*j +: 32]}
                     - {prev_ff[j][31], prev_ff[j]};
      end
      den_w = {1'b0, loff_ff} + {1'b0, roff_ff};
      num_neg_w = num_ff[32];
      num_mag_w = num_neg_w ? 32'(33'd0 - num_ff) : num_ff[31:0];
      s_mag_w = abs32(sin_w);
      c_mag_w = abs32(cos_w);
      h_mag_w = abs32(h_ff);
      h2_mag_w = abs32(h2_ff);
      us_w = {s_mag_w[30:0], 1'b0};
      d_sel_w = cmd.pass ? dm_ff : dr_ff;
      d_mag_w = abs32(d_sel_w);
      off_sel_w = cmd.pass ? moff_ff : roff_ff;
      ua_w = a_ff[58] ? 58'(59'd0 - a_ff) : a_ff[57:0];
      ud_w = {num_mag_w, 30'd0};
      round_up_w = {div_rem[61:0], 1'b0} >= {1'b0, ud_w};
      qr_w = {1'b0, div_q[30:0]} + 32'(round_up_w);
      chord_neg_w = sin_w[31] ^ a_ff[58] ^ num_neg_w;
   end

   always_comb begin
      lscale_in = lscale_ff;
      rscale_in = rscale_ff;
      mscale_in = mscale_ff;
      loff_in = loff_ff;
      roff_in = roff_ff;
      moff_in = moff_ff;
      prev_in = prev_ff;
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      acc_h_in = acc_h_ff;
      mag_in = mag_ff;
      sgn_in = sgn_ff;
      dl_in = dl_ff;
      dr_in = dr_ff;
      dm_in = dm_ff;
      h_in = h_ff;
      h2_in = h2_ff;
      num_in = num_ff;
      bam_in = bam_ff;
      half_in = half_ff;
      t_in = t_ff;
      a_in = a_ff;
      pacc_in = pacc_ff;
      ovf_in = ovf_ff;
      out_x_in = out_x_ff;
      out_y_in = out_y_ff;
      out_h_in = out_h_ff;
      mul_a = '0;
      mul_b = '0;
      div_start = 1'b0;
      div_dividend = pacc_ff;
      div_divisor = {num_mag_w, 60'd0};
      div_bits = tw_odo_pkg::CHORD_BITS;
      cor_start = 1'b0;
      cor_angle = acc_h_ff + half_ff;
      v_w = '0;
      hsign_w = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (csr_valid) begin
         unique case (tw_odo_pkg::reg_index_type'(csr_index))
            tw_odo_pkg::REG_LEFT_SCALE:    lscale_in = csr_data[31:0];
            tw_odo_pkg::REG_RIGHT_SCALE:   rscale_in = csr_data[31:0];
            tw_odo_pkg::REG_MIDDLE_SCALE:  mscale_in = csr_data[31:0];
            tw_odo_pkg::REG_LEFT_OFFSET:   loff_in = csr_data[23:0];
            tw_odo_pkg::REG_RIGHT_OFFSET:  roff_in = csr_data[23:0];
            tw_odo_pkg::REG_MIDDLE_OFFSET: moff_in = csr_data[23:0];
            tw_odo_pkg::REG_INIT_POSITION: begin
               acc_x_in = csr_data[63:32];
               acc_y_in = csr_data[31:0];
            end
            tw_odo_pkg::REG_INIT_HEADING:  acc_h_in = csr_data[31:0];
         endcase
      end

      unique case (cmd.op)
         tw_odo_pkg::OP_LOAD: begin
            for (int j = 0; j < 3; j++) begin
               sgn_in[j] = diff_w[j][32];
               mag_in[j] = diff_w[j][32] ? 32'(33'sd0 - diff_w[j]) : diff_w[j][31:0];
               prev_in[j] = req_tdata[32*j +: 32];
            end
         end
         tw_odo_pkg::OP_MUL_L: begin
            mul_a = mag_ff[0];
            mul_b = lscale_ff;
         end
         tw_odo_pkg::OP_MUL_R: begin
            dl_in = dist_of(prod_ff, sgn_ff[0]);
            mul_a = mag_ff[1];
            mul_b = rscale_ff;
         end
         tw_odo_pkg::OP_MUL_M: begin
            dr_in = dist_of(prod_ff, sgn_ff[1]);
            mul_a = mag_ff[2];
            mul_b = mscale_ff;
         end
         tw_odo_pkg::OP_NUM: begin
            dm_in = dist_of(prod_ff, sgn_ff[2]);
            num_in = {dl_ff[31], dl_ff} - {dr_ff[31], dr_ff};
         end
         tw_odo_pkg::OP_BAMMUL: begin
            // straight step values stand unless a turn replaces them
            h_in = dr_ff;
            h2_in = dm_ff;
            bam_in = '0;
            half_in = '0;
            mul_a = num_mag_w;
            mul_b = {2'b0, tw_odo_pkg::TURN_CONST};
         end
         tw_odo_pkg::OP_DIV_BAM: begin
            div_start = 1'b1;
            div_dividend = {26'd0, prod_ff};
            div_divisor = {6'd0, den_w, 61'd0};
            div_bits = tw_odo_pkg::BAM_BITS;
         end
         tw_odo_pkg::OP_HALF: begin
            bam_in = num_neg_w ? 32'd0 - div_q[31:0] : div_q[31:0];
            half_in = num_neg_w ? 32'd0 - div_q[32:1] : div_q[32:1];
            cor_start = 1'b1;
            cor_angle = half_in;
         end
         tw_odo_pkg::OP_A1: begin
            mul_a = d_mag_w;
            mul_b = {7'd0, den_w};
         end
         tw_odo_pkg::OP_A2: begin
            t_in = signed_of(prod_ff, d_sel_w[31]);
            mul_a = {8'd0, off_sel_w};
            mul_b = num_mag_w;
         end
         tw_odo_pkg::OP_A3: begin
            a_in = 59'(t_ff + signed_of(prod_ff, num_neg_w));
         end
         tw_odo_pkg::OP_P1: begin
            mul_a = us_w;
            mul_b = ua_w[31:0];
         end
         tw_odo_pkg::OP_P2: begin
            pacc_in = {26'd0, prod_ff};
            mul_a = us_w;
            mul_b = {6'd0, ua_w[57:32]};
         end
         tw_odo_pkg::OP_P3: begin
            pacc_in = pacc_ff + {prod_ff[57:0], 32'd0};
         end
         tw_odo_pkg::OP_DIV_CH: begin
            div_start = 1'b1;
            ovf_in = {3'd0, pacc_ff} >= {num_mag_w, 61'd0};
         end
         tw_odo_pkg::OP_CHORD: begin
            hsign_w = $signed((ovf_ff || qr_w[31]) ? tw_odo_pkg::SAT_MAX : qr_w);
            if (chord_neg_w) begin
               hsign_w = -hsign_w;
            end
            if (cmd.pass) begin
               h2_in = hsign_w;
            end else begin
               h_in = hsign_w;
            end
         end
         tw_odo_pkg::OP_POS: begin
            cor_start = 1'b1;
         end
         tw_odo_pkg::OP_X1: begin
            mul_a = h_mag_w;
            mul_b = c_mag_w;
         end
         tw_odo_pkg::OP_X2: begin
            t_in = signed_of(prod_ff, h_ff[31] ^ cos_w[31]);
            mul_a = h2_mag_w;
            mul_b = s_mag_w;
         end
         tw_odo_pkg::OP_X3: begin
            v_w = t_ff - signed_of(prod_ff, h2_ff[31] ^ sin_w[31]);
            acc_x_in = acc_x_ff + round30(v_w);
            mul_a = h_mag_w;
            mul_b = s_mag_w;
         end
         tw_odo_pkg::OP_Y1: begin
            t_in = signed_of(prod_ff, h_ff[31] ^ sin_w[31]);
            mul_a = h2_mag_w;
            mul_b = c_mag_w;
         end
         tw_odo_pkg::OP_Y2: begin
            v_w = t_ff + signed_of(prod_ff, h2_ff[31] ^ cos_w[31]);
            acc_y_in = acc_y_ff + round30(v_w);
            acc_h_in = acc_h_ff + bam_ff;
         end
         tw_odo_pkg::OP_PUSH: begin
            out_x_in = acc_x_ff;
            out_y_in = acc_y_ff;
            out_h_in = acc_h_ff;
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lscale_ff <= '0;
         rscale_ff <= '0;
         mscale_ff <= '0;
         loff_ff <= '0;
         roff_ff <= '0;
         moff_ff <= '0;
         prev_ff <= '{default: '0};
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         acc_h_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lscale_ff <= lscale_in;
         rscale_ff <= rscale_in;
         mscale_ff <= mscale_in;
         loff_ff <= loff_in;
         roff_ff <= roff_in;
         moff_ff <= moff_in;
         prev_ff <= prev_in;
         acc_x_ff <= acc_x_in;
         acc_y_ff <= acc_y_in;
         acc_h_ff <= acc_h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff <= mag_in;
      sgn_ff <= sgn_in;
      dl_ff <= dl_in;
      dr_ff <= dr_in;
      dm_ff <= dm_in;
      h_ff <= h_in;
      h2_ff <= h2_in;
      num_ff <= num_in;
      bam_ff <= bam_in;
      half_ff <= half_in;
      t_ff <= t_in;
      a_ff <= a_in;
      pacc_ff <= pacc_in;
      ovf_ff <= ovf_in;
      prod_ff <= mul_a * mul_b;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_h_ff <= out_h_in;
   end

   assign status.turn = (num_ff != '0) && (den_w != '0);
   assign status.div_busy = div_busy;
   assign status.cordic_busy = cor_busy;
   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {out_h_ff, out_y_ff, out_x_ff};
endmodule

>>> design/tw_odo_ctrl.sv
// Sequencer of the odometry core: steps the datapath through one sample.
// Depends on tw_odo_pkg.
module tw_odo_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  tw_odo_pkg::status_type status,
   output tw_odo_pkg::cmd_type    cmd
);
   tw_odo_pkg::state_type state_ff, state_in;
   logic                  pass_ff, pass_in;

   always_comb begin
      state_in = state_ff;
      pass_in = pass_ff;
      req_tready = 1'b0;
      cmd.op = tw_odo_pkg::OP_NONE;
      cmd.pass = pass_ff;
      unique case (state_ff)
         tw_odo_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = tw_odo_pkg::OP_LOAD;
               state_in = tw_odo_pkg::ST_MUL_L;
            end
         end
         tw_odo_pkg::ST_MUL_L: begin
            cmd.op = tw_odo_pkg::OP_MUL_L;
            state_in = tw_odo_pkg::ST_MUL_R;
         end
         tw_odo_pkg::ST_MUL_R: begin
            cmd.op = tw_odo_pkg::OP_MUL_R;
            state_in = tw_odo_pkg::ST_MUL_M;
         end
         tw_odo_pkg::ST_MUL_M: begin
            cmd.op = tw_odo_pkg::OP_MUL_M;
            state_in = tw_odo_pkg::ST_NUM;
         end
         tw_odo_pkg::ST_NUM: begin
            cmd.op = tw_odo_pkg::OP_NUM;
            state_in = tw_odo_pkg::ST_BAMMUL;
         end
         tw_odo_pkg::ST_BAMMUL: begin
            cmd.op = tw_odo_pkg::OP_BAMMUL;
            pass_in = 1'b0;
            state_in = status.turn ? tw_odo_pkg::ST_DIV_BAM : tw_odo_pkg::ST_POS;
         end
         tw_odo_pkg::ST_DIV_BAM: begin
            cmd.op = tw_odo_pkg::OP_DIV_BAM;
            state_in = tw_odo_pkg::ST_BAM_WAIT;
         end
         tw_odo_pkg::ST_BAM_WAIT: begin
            if (!status.div_busy) begin
               state_in = tw_odo_pkg::ST_HALF;
            end
         end
         tw_odo_pkg::ST_HALF: begin
            cmd.op = tw_odo_pkg::OP_HALF;
            state_in = tw_odo_pkg::ST_HALF_WAIT;
         end
         tw_odo_pkg::ST_HALF_WAIT: begin
            if (!status.cordic_busy) begin
               state_in = tw_odo_pkg::ST_A1;
            end
         end
         tw_odo_pkg::ST_A1: begin
            cmd.op = tw_odo_pkg::OP_A1;
            state_in = tw_odo_pkg::ST_A2;
         end
         tw_odo_pkg::ST_A2: begin
            cmd.op = tw_odo_pkg::OP_A2;
            state_in = tw_odo_pkg::ST_A3;
         end
         tw_odo_pkg::ST_A3: begin
            cmd.op = tw_odo_pkg::OP_A3;
            state_in = tw_odo_pkg::ST_P1;
         end
         tw_odo_pkg::ST_P1: begin
            cmd.op = tw_odo_pkg::OP_P1;
            state_in = tw_odo_pkg::ST_P2;
         end
         tw_odo_pkg::ST_P2: begin
            cmd.op = tw_odo_pkg::OP_P2;
            state_in = tw_odo_pkg::ST_P3;
         end
         tw_odo_pkg::ST_P3: begin
            cmd.op = tw_odo_pkg::OP_P3;
            state_in = tw_odo_pkg::ST_DIV_CH;
         end
         tw_odo_pkg::ST_DIV_CH: begin
            cmd.op = tw_odo_pkg::OP_DIV_CH;
            state_in = tw_odo_pkg::ST_CH_WAIT;
         end
         tw_odo_pkg::ST_CH_WAIT: begin
            if (!status.div_busy) begin
               state_in = tw_odo_pkg::ST_CHORD;
            end
         end
         tw_odo_pkg::ST_CHORD: begin
            // forward chord first, then the sideways one
            cmd.op = tw_odo_pkg::OP_CHORD;
            pass_in = !pass_ff;
            state_in = pass_ff ? tw_odo_pkg::ST_POS : tw_odo_pkg::ST_A1;
         end
         tw_odo_pkg::ST_POS: begin
            cmd.op = tw_odo_pkg::OP_POS;
            state_in = tw_odo_pkg::ST_POS_WAIT;
         end
         tw_odo_pkg::ST_POS_WAIT: begin
            if (!status.cordic_busy) begin
               state_in = tw_odo_pkg::ST_X1;
            end
         end
         tw_odo_pkg::ST_X1: begin
            cmd.op = tw_odo_pkg::OP_X1;
            state_in = tw_odo_pkg::ST_X2;
         end
         tw_odo_pkg::ST_X2: begin
            cmd.op = tw_odo_pkg::OP_X2;
            state_in = tw_odo_pkg::ST_X3;
         end
         tw_odo_pkg::ST_X3: begin
            cmd.op = tw_odo_pkg::OP_X3;
            state_in = tw_odo_pkg::ST_Y1;
         end
         tw_odo_pkg::ST_Y1: begin
            cmd.op = tw_odo_pkg::OP_Y1;
            state_in = tw_odo_pkg::ST_Y2;
         end
         tw_odo_pkg::ST_Y2: begin
            cmd.op = tw_odo_pkg::OP_Y2;
            state_in = tw_odo_pkg::ST_PUSH;
         end
         tw_odo_pkg::ST_PUSH: begin
            if (status.out_free) begin
               cmd.op = tw_odo_pkg::OP_PUSH;
               state_in = tw_odo_pkg::ST_IDLE;
            end
         end
         default: state_in = tw_odo_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tw_odo_pkg::ST_IDLE;
         pass_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff <= pass_in;
      end
   end
endmodule

>>> design/three_wheel_odometry_core.sv
// Three-wheel arc odometry core: top level joining sequencer and datapath.
// Latency differs for samples with and without a turn; the bit-serial divider
// (62 steps, then 31 per chord) and the 24-step shared CORDIC set it.
// One sample at a time, taken only when idle; a waiting result holds the push.
// Reset (synchronous, active high) clears configuration, previous readings and pose.
// Depends on tw_odo_pkg, tw_odo_ctrl, tw_odo_datapath and the macros header.
`include "three_wheel_odometry_core_macros.svh"
module three_wheel_odometry_core (
   input  logic        clock,
   input  logic        reset,
   // sample stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // left_count, right_count, middle_count
   // pose stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,  // pos_x, pos_y, heading
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   tw_odo_pkg::cmd_type    cmd;
   tw_odo_pkg::status_type status;

   // register writes are always taken and land at once; issue them with no sample in flight
   assign csr_ready = 1'b1;

   // sequencer: one transaction in, a micro-operation list per sample, longer for a turn
   tw_odo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: shared multiplier, divider and CORDIC, plus the result register
   tw_odo_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // hold off new samples while any iterative unit is still at work
   `ODO_ASSERT(a_div_not_idle, clock, reset, status.div_busy |-> !req_tready)
   `ODO_ASSERT(a_cordic_not_idle, clock, reset, status.cordic_busy |-> !req_tready)
   // a committed pose shows up as a valid transaction next cycle
   `ODO_ASSERT_NEXT(a_push_valid, clock, reset, cmd.op == tw_odo_pkg::OP_PUSH, rsp_tvalid)
   // an accepted sample leaves the sequencer busy
   `ODO_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready)
endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for three_wheel_odometry_core: drives encoder samples and register
// writes, predicts each pose in SystemVerilog and compares every returned transaction.
// Depends on tw_odo_pkg and the core RTL only.
module testbench;

   localparam longint DIST_SAT   = 64'sd2147483647;
   localparam longint TURN_GAIN  = 64'sd683565276;
   localparam longint TRIG_GAIN  = 64'sd652032874;
   localparam int     IDLE_LIMIT = 4000;   // cycles without any transaction
   localparam int     SETTLE     = 300;    // more than the turning latency

   // rotation angles per CORDIC step, binary angle units
   localparam longint ROT_ANGLE [32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
      5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
      10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   // predictor copy of registers and pose
   logic [31:0] scale_l, scale_r, scale_m;
   logic [23:0] offs_l, offs_r, offs_m;
   logic [31:0] last_l, last_r, last_m;
   logic [31:0] pose_x, pose_y, pose_heading;

   logic [95:0] pose_expected [$];
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   int          burst_left = 0;
   int          stall_clock = 0;
   logic [31:0] enc_l, enc_r, enc_m;      // running encoder readings for walks

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   three_wheel_odometry_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data));

   // ---------------------------------------------------------------- predictor

   // Wheel travel in Q.16: exact reading change times scale, rounded, saturated.
   function automatic longint travel(input logic [31:0] cnt, input logic [31:0] prev,
                                     input logic [31:0] scale);
      longint      diff;
      logic [63:0] mag;
      logic [63:0] p;
      diff = longint'($signed(cnt)) - longint'($signed(prev));
      mag  = diff < 0 ? -diff : diff;
      p    = mag * {32'd0, scale};
      p    = (p >> 8) + p[7];
      if (p > DIST_SAT) p = DIST_SAT;
      return diff < 0 ? -longint'(p) : longint'(p);
   endfunction

   // Sine and cosine in Q1.30 by rotation over the octant residual.
   function automatic void sine_cosine(input logic [31:0] ang, output longint s,
                                       output longint c);
      logic [31:0] shifted;
      logic [1:0]  quad;
      logic [31:0] resid;
      longint      z, x, y, nx;
      shifted = ang + 32'h2000_0000;
      quad    = shifted[31:30];
      resid   = ang - {quad, 30'd0};
      z = longint'($signed(resid));
      x = TRIG_GAIN;
      y = 0;
      for (int i = 0; i < tw_odo_pkg::TRIG_ITERATIONS && i < 32; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - ROT_ANGLE[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + ROT_ANGLE[i];
         end
         x = nx;
      end
      case (quad)
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   // Chord length 2*s*(d*den + off*num) / (num * 2^30), rounded half up, saturated.
   function automatic longint chord_len(input longint s, input longint d, input longint off,
                                        input longint num, input longint den);
      longint       a;
      logic [127:0] us, ua, ud, prod, q, rem;
      logic         neg;
      a    = d * den + off * num;
      us   = 128'(s < 0 ? -s : s) * 2;
      ua   = 128'(a < 0 ? -a : a);
      ud   = 128'(num < 0 ? -num : num) << 30;
      neg  = (s < 0) ^ (a < 0) ^ (num < 0);
      prod = us * ua;
      if ((prod >> 64) >= ud) begin
         q = 128'(DIST_SAT);
      end else begin
         q   = prod / ud;
         rem = prod % ud;
         if (rem >= ud - rem) q = q + 1;
         if (q > DIST_SAT) q = 128'(DIST_SAT);
      end
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint round_q30(input longint v);
      if (v >= 0) return (v + (64'sd1 <<< 29)) >>> 30;
      return -(((-v) + (64'sd1 <<< 29)) >>> 30);
   endfunction

   // Advance the predicted pose by one sample; returns the packed expected result.
   function automatic logic [95:0] advance_pose(input logic [31:0] l, input logic [31:0] r,
                                                input logic [31:0] m);
      longint      dl, dr, dm, num, den, bam, half, h, h2, s, c;
      logic [31:0] mid_heading;
      dl  = travel(l, last_l, scale_l);
      dr  = travel(r, last_r, scale_r);
      dm  = travel(m, last_m, scale_m);
      num = dl - dr;
      den = longint'(offs_l) + longint'(offs_r);
      bam = 0;
      half = 0;
      h   = dr;
      h2  = dm;
      last_l = l;
      last_r = r;
      last_m = m;
      if (num != 0 && den != 0) begin
         bam  = num * TURN_GAIN / den;
         half = bam / 2;
         sine_cosine(half[31:0], s, c);
         h  = chord_len(s, dr, longint'(offs_r), num, den);
         h2 = chord_len(s, dm, longint'(offs_m), num, den);
      end
      mid_heading = pose_heading + half[31:0];
      sine_cosine(mid_heading, s, c);
      pose_x = pose_x + 32'(round_q30(h * c - h2 * s));
      pose_y = pose_y + 32'(round_q30(h * s + h2 * c));
      pose_heading = pose_heading + bam[31:0];
      return {pose_heading, pose_y, pose_x};
   endfunction

   // ---------------------------------------------------------------- drivers

   // Send one sample; the sender works in bursts with random gaps between them.
   task automatic send_sample(input logic [31:0] l, input logic [31:0] r,
                              input logic [31:0] m);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {m, r, l};
      do @(posedge clock); while (!req_tready);
      pose_expected.push_back(advance_pose(l, r, m));
      burst_left--;
   endtask

   // Hold until every pose has returned and the core has gone quiet.
   task automatic drain;
      if (burst_left != 0 || req_tvalid) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
      end
      while (pose_expected.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input tw_odo_pkg::reg_index_type idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         tw_odo_pkg::REG_LEFT_SCALE:    scale_l = val[31:0];
         tw_odo_pkg::REG_RIGHT_SCALE:   scale_r = val[31:0];
         tw_odo_pkg::REG_MIDDLE_SCALE:  scale_m = val[31:0];
         tw_odo_pkg::REG_LEFT_OFFSET:   offs_l = val[23:0];
         tw_odo_pkg::REG_RIGHT_OFFSET:  offs_r = val[23:0];
         tw_odo_pkg::REG_MIDDLE_OFFSET: offs_m = val[23:0];
         tw_odo_pkg::REG_INIT_POSITION: begin pose_x = val[63:32]; pose_y = val[31:0]; end
         tw_odo_pkg::REG_INIT_HEADING:  pose_heading = val[31:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(input logic [31:0] sl, input logic [31:0] sr,
                            input logic [31:0] sm, input logic [23:0] ol,
                            input logic [23:0] orr, input logic [23:0] om,
                            input logic [63:0] pos, input logic [31:0] hd);
      write_reg(tw_odo_pkg::REG_LEFT_SCALE, {32'd0, sl});
      write_reg(tw_odo_pkg::REG_RIGHT_SCALE, {32'd0, sr});
      write_reg(tw_odo_pkg::REG_MIDDLE_SCALE, {32'd0, sm});
      write_reg(tw_odo_pkg::REG_LEFT_OFFSET, {40'd0, ol});
      write_reg(tw_odo_pkg::REG_RIGHT_OFFSET, {40'd0, orr});
      write_reg(tw_odo_pkg::REG_MIDDLE_OFFSET, {40'd0, om});
      write_reg(tw_odo_pkg::REG_INIT_POSITION, pos);
      write_reg(tw_odo_pkg::REG_INIT_HEADING, {32'd0, hd});
   endtask

   // Plausible robot: scales near a 2.75 inch wheel, offsets of a few inches.
   task automatic write_plausible;
      write_all(32'($urandom_range(200000, 800000)), 32'($urandom_range(200000, 800000)),
                32'($urandom_range(200000, 800000)), 24'($urandom_range(65536, 786432)),
                24'($urandom_range(65536, 786432)), 24'($urandom_range(0, 786432)),
                {$urandom, $urandom}, $urandom);
   endtask

   // One step of a walk: mostly small wheel moves, sometimes straight, rarely wild.
   task automatic walk_step;
      int kind;
      int fwd;
      kind = $urandom_range(0, 99);
      fwd  = $urandom_range(0, 400) - 200;
      if (kind < 30) begin
         enc_l = enc_l + fwd;
         enc_r = enc_r + fwd;
         enc_m = enc_m + $urandom_range(0, 20) - 10;
      end else if (kind < 90) begin
         enc_l = enc_l + fwd + $urandom_range(0, 200) - 100;
         enc_r = enc_r + fwd + $urandom_range(0, 200) - 100;
         enc_m = enc_m + $urandom_range(0, 200) - 100;
      end else if (kind < 95) begin
         enc_l = enc_l + $urandom_range(0, 200000) - 100000;
         enc_r = enc_r - $urandom_range(0, 200000) + 100000;
         enc_m = enc_m + $urandom_range(0, 200000) - 100000;
      end else begin
         enc_l = $urandom;
         enc_r = $urandom;
         enc_m = $urandom;
      end
      send_sample(enc_l, enc_r, enc_m);
   endtask

   // ---------------------------------------------------------------- tests

   // Registers still at reset: every distance is zero and the pose stays put.
   task automatic test_reset_state;
      send_sample(32'd0, 32'd0, 32'd0);
      send_sample(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678);
      send_sample(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
   endtask

   // Field extremes, no turn, pure turns, and readings jumping far enough to saturate.
   task automatic test_directed;
      write_plausible();
      enc_l = 0; enc_r = 0; enc_m = 0;
      send_sample(32'd0, 32'd0, 32'd0);
      send_sample(32'd360, 32'd360, 32'd0);          // straight ahead
      send_sample(32'd360, 32'd360, 32'd90);         // pure sideways slide
      send_sample(32'd720, 32'd0, 32'd90);           // spin one way
      send_sample(32'd0, 32'd720, 32'd90);           // spin back
      send_sample(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_sample(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_sample(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_sample(32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000);
      send_sample(32'h7fff_fff0, 32'h7fff_ffff, 32'h7fff_ffff);
      send_sample(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
      drain();
   endtask

   // Zero track width: every step is taken as a step without a turn.
   task automatic test_zero_track;
      write_all(32'd400000, 32'd500000, 32'd600000, 24'd0, 24'd0, 24'hff_ffff,
                64'h0001_0000_ffff_0000, 32'h4000_0000);
      send_sample(32'd100, 32'd50, 32'd10);
      send_sample(32'h8000_0000, 32'd9000, 32'h7fff_ffff);
      send_sample(32'd0, 32'hffff_fff0, 32'd77);
      drain();
   endtask

   // Extreme registers: full scales and widest offsets, then tiny or zero ones; position at the wrap edges.
   task automatic test_extreme_config;
      write_all(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 24'hff_ffff, 24'hff_ffff,
                24'hff_ffff, 64'h7fff_ffff_8000_0000, 32'hffff_ffff);
      send_sample(32'd1, 32'd0, 32'd1);
      send_sample(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_sample(32'd5, 32'd5, 32'd5);
      drain();
      write_all(32'd1, 32'hffff_ffff, 32'd0, 24'd1, 24'd0, 24'd0,
                64'h8000_0000_7fff_ffff, 32'd0);
      send_sample(32'h7fff_ffff, 32'd1, 32'd3);
      send_sample(32'd0, 32'd2, 32'd3);
      send_sample(32'h1234_5678, 32'h8765_4321, 32'd3);
      drain();
   endtask

   // Random walks under a series of register settings, with some raw noise.
   task automatic test_random_walks;
      for (int phase = 0; phase < 8; phase++) begin
         if (phase % 4 == 3)
            write_all($urandom, $urandom, $urandom, 24'($urandom), 24'($urandom),
                      24'($urandom), {$urandom, $urandom}, $urandom);
         else
            write_plausible();
         for (int n = 0; n < 195; n++) walk_step();
         drain();
      end
   endtask

   // ---------------------------------------------------------------- checking

   // Receiver stalls on a pattern of its own: free, random, long blocks, then mostly ready.
   always @(posedge clock) begin
      stall_clock <= stall_clock + 1;
      case (stall_clock[9:8])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= $urandom_range(0, 1);
         2'd2: rsp_tready <= (stall_clock[4:0] > 5'd20);
         default: rsp_tready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Compare each pose transaction against the oldest prediction.
   always @(posedge clock) begin
      logic [95:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pose_expected.size() == 0) begin
            $error("pose returned with none outstanding: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pose_expected.pop_front();
            if (rsp_tdata[31:0] !== want[31:0]) begin
               $error("pos_x expected %h actual %h", want[31:0], rsp_tdata[31:0]);
               mismatch_count++;
            end
            if (rsp_tdata[63:32] !== want[63:32]) begin
               $error("pos_y expected %h actual %h", want[63:32], rsp_tdata[63:32]);
               mismatch_count++;
            end
            if (rsp_tdata[95:64] !== want[95:64]) begin
               $error("heading expected %h actual %h", want[95:64], rsp_tdata[95:64]);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end the run once no transaction has moved for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      scale_l = 0; scale_r = 0; scale_m = 0;
      offs_l = 0; offs_r = 0; offs_m = 0;
      last_l = 0; last_r = 0; last_m = 0;
      pose_x = 0; pose_y = 0; pose_heading = 0;
      enc_l = 0; enc_r = 0; enc_m = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      drain();
      test_directed();
      test_zero_track();
      test_extreme_config();
      test_random_walks();
      drain();
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/tw_odo_pkg.sv
design/tw_odo_div.sv
design/tw_odo_cordic.sv
design/tw_odo_datapath.sv
design/tw_odo_ctrl.sv
design/three_wheel_odometry_core.sv
bench/testbench.sv
